@@ hw/rtl/scmc_pkg.sv @@
// Package: types, constants and codes shared by the strip common-mode correction block.
package scmc_pkg;

   localparam int DETECTORS   = 16;
   localparam int STRIPS      = 640;
   localparam int CHUNK       = 32;
   localparam int ASIC_STRIPS = 64;

   localparam int DET_W   = 4;
   localparam int STRIP_W = 10;
   localparam int RAW_W   = 12;
   localparam int PED_W   = 16;
   localparam int SIG_W   = 12;
   localparam int COARSE_W = 17;
   localparam int FINE_W   = 18;
   localparam int SUM_W    = 23;
   localparam int CNT_W    = 6;
   localparam int POS_W    = $clog2(CHUNK);
   localparam int CAL_DEPTH = DETECTORS * STRIPS;
   localparam int CAL_AW    = $clog2(CAL_DEPTH);
   localparam int CAL_W     = PED_W + SIG_W + 1;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [3:0] CUT_RESET  = 4'd6;
   localparam logic [5:0] EDGE_RESET = 6'd3;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_PROCESS = 1'b1;

   localparam logic [0:0] REG_CUT_FACTOR  = 1'b0;
   localparam logic [0:0] REG_EDGE_STRIPS = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

@@ hw/rtl/strip_common_mode_correction.sv @@
// Top level: pedestal subtraction, chunk baseline accumulation and common-mode output.
// A load word writes the calibration memory from the idle state; a sample that does not
// close a chunk passes through accept with calibration memory read, a lookup state, then
// accumulate. A chunk-closing sample then goes to the shared bit-serial divider (start,
// 23 quotient bits, take the result), or skips it when the good count is under two,
// and then emits 32 result words, one per cycle while rsp_ready is high. The
// calibration memory (16 x 640 words of pedestal, sigma, bad flag) has no reset and
// must be loaded before samples for those strips arrive.
module strip_common_mode_correction (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [3:0]                        req_detector,
   input  logic [9:0]                        req_strip,
   input  logic [11:0]                       req_raw_adc,
   input  logic [15:0]                       req_pedestal_value,
   input  logic [11:0]                       req_sigma_value,
   input  logic                              req_bad_strip,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_out_detector,
   output logic [9:0]                        rsp_out_strip,
   output logic signed [16:0]                rsp_coarse_signal,
   output logic signed [17:0]                rsp_fine_signal,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [5:0]                        csr_data
);
   import scmc_pkg::*;

   state_type state_ff, state_in;

   logic [3:0] cut_ff;
   logic [5:0] edge_ff;

   logic [CAL_W-1:0] cal_mem [CAL_DEPTH];
   logic [CAL_W-1:0] cal_rd_ff;
   logic signed [COARSE_W-1:0] buf_mem [CHUNK];
   logic signed [COARSE_W-1:0] buf_rd_ff;

   logic [DET_W-1:0]   det_ff, det_in;
   logic [STRIP_W-1:0] strip_ff, strip_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] base_ff, base_in;
   logic [POS_W-1:0]   k_ff, k_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   logic [STRIP_W-1:0] out_strip_ff, out_strip_in;

   logic               in_range, accept;
   logic [CAL_AW-1:0]  req_addr;
   logic [POS_W-1:0]   pos;
   logic signed [COARSE_W-1:0] coarse;
   logic [COARSE_W-1:0] mag;
   logic [SIG_W+3:0]   cut_lim;
   logic               good, buf_wr, buf_rd;
   logic signed [SUM_W:0] acc;
   logic [CNT_W-1:0]   cnt_base;
   logic signed [SUM_W-1:0] sum_base;
   logic               div_start, div_busy, div_done;
   logic signed [SUM_W-1:0] quotient;

   assign in_range = (32'(req_detector) < DETECTORS) && (req_strip != '0)
                     && (32'(req_strip) <= STRIPS);
   assign req_addr = CAL_AW'(req_detector) * CAL_AW'(STRIPS) + CAL_AW'(req_strip - 1'b1);
   assign req_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign pos = POS_W'(strip_ff - 1'b1);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff  <= CUT_RESET;
         edge_ff <= EDGE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CUT_FACTOR:  cut_ff  <= csr_data[3:0];
            REG_EDGE_STRIPS: edge_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Calibration memory: write on load, registered read of the accepted word's entry.
   always_ff @(posedge clock) begin
      if (accept && in_range && req_command == CMD_LOAD)
         cal_mem[req_addr] <= {req_pedestal_value, req_sigma_value, req_bad_strip};
      if (accept)
         cal_rd_ff <= cal_mem[req_addr];
   end

   // Coarse value and cut check on the read calibration word.
   always_comb begin
      coarse  = $signed({1'b0, raw_ff, 4'b0000}) - $signed({1'b0, cal_rd_ff[CAL_W-1 -: PED_W]});
      mag     = coarse[COARSE_W-1] ? COARSE_W'(-coarse) : COARSE_W'(coarse);
      cut_lim = (SIG_W+4)'(cut_ff) * (SIG_W+4)'(cal_rd_ff[SIG_W:1]);
      good    = (mag < {1'b0, cut_lim}) && !cal_rd_ff[0]
                && !(6'(strip_ff % ASIC_STRIPS) < edge_ff);
      cnt_base = (pos == '0) ? '0 : cnt_ff;
      sum_base = (pos == '0) ? '0 : sum_ff;
      acc = (SUM_W+1)'(sum_base) + (SUM_W+1)'(coarse);
   end

   assign buf_wr = (state_ff == ST_ACCUM);
   assign buf_rd = 1'b1;

   // Chunk buffer memory.
   always_ff @(posedge clock) begin
      if (buf_wr)
         buf_mem[pos] <= coarse;
      if (buf_rd)
         buf_rd_ff <= buf_mem[k_in];
   end

   scmc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      det_in       = det_ff;
      strip_in     = strip_ff;
      raw_in       = raw_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_last_in  = out_last_ff;
      out_strip_in = out_strip_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range && req_command == CMD_PROCESS) begin
               det_in   = req_detector;
               strip_in = req_strip;
               raw_in   = req_raw_adc;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_ACCUM;
         ST_ACCUM: begin
            sum_in = sum_base;
            cnt_in = cnt_base;
            if (good) begin
               cnt_in = cnt_base + 1'b1;
               if (acc > $signed((SUM_W+1)'(SUM_MAX)))
                  sum_in = SUM_MAX;
               else if (acc < $signed({1'b1, SUM_MIN}))
                  sum_in = SUM_MIN;
               else
                  sum_in = acc[SUM_W-1:0];
            end
            if (pos == POS_W'(CHUNK - 1)) begin
               k_in = '0;
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff < CNT_W'(2)) begin
               base_in  = sum_ff;
               state_in = ST_EMIT;
            end else if (div_done) begin
               base_in  = quotient;
               state_in = ST_EMIT;
            end else if (!div_busy) begin
               div_start = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_last_in  = (k_ff == POS_W'(CHUNK - 1));
               out_strip_in = strip_ff - STRIP_W'(CHUNK - 1) + STRIP_W'(k_ff);
               if (k_ff == POS_W'(CHUNK - 1)) begin
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
               k_in = k_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer and output registers; the output word is taken from the chunk buffer read.
   logic signed [COARSE_W-1:0] out_coarse_ff;
   logic [DET_W-1:0]           out_det_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         k_ff         <= k_in;
      end
      det_ff       <= det_in;
      strip_ff     <= strip_in;
      raw_ff       <= raw_in;
      base_ff      <= base_in;
      out_last_ff  <= out_last_in;
      out_strip_ff <= out_strip_in;
      if (state_ff == ST_EMIT && (!out_valid_ff || rsp_ready)) begin
         out_coarse_ff <= buf_rd_ff;
         out_det_ff    <= det_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_detector  = out_det_ff;
   assign rsp_out_strip     = out_strip_ff;
   assign rsp_coarse_signal = out_coarse_ff;
   assign rsp_fine_signal   = FINE_W'(out_coarse_ff) - FINE_W'(base_ff);
   assign rsp_last          = out_last_ff;

   // No new sample is taken while a result word is pending.
   a_no_accept_when_out: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !req_ready) else $error("input accepted with result pending");
   // Divider only runs in the divide state.
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIVIDE) else $error("divider busy outside divide");
   // Final word of a chunk returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && state_ff == ST_EMIT) |-> 1'b0)
      else $error("emit continued past last word");

endmodule

@@ hw/rtl/scmc_divider.sv @@
// Shared restoring divider: signed sum over unsigned count, truncated toward zero.
module scmc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [scmc_pkg::SUM_W-1:0] dividend,
   input  logic        [scmc_pkg::CNT_W-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic signed [scmc_pkg::SUM_W-1:0] quotient
);
   import scmc_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W+1:0]  trial;

   // One quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[SUM_W-1]} - {2'b00, den_ff};
         if (!trial[CNT_W+1]) begin
            rem_in = trial[CNT_W:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule
